// ----- rtl/core/fpba_pkg.sv -----
// Package for the fit-policy block allocator: field widths, command and
// policy codes, and the reset value of the blocks-in-use register.
// No dependencies; every other file of the block but fpba_mem uses it by scoped names.
package fpba_pkg;

  // Fixed field widths of the input and result transactions and of the config write.
  localparam int unsigned IndexBits  = 6;
  localparam int unsigned PolicyBits = 2;
  localparam int unsigned CfgBits    = 7;

  // Reset value of the blocks-in-use register.
  localparam logic [CfgBits-1:0] CfgReset = 7'd64;

  // Command codes.
  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdAlloc = 1'b1;

  // Fit policy codes; the fourth code is not a policy and is dropped.
  localparam logic [PolicyBits-1:0] PolFirst = 2'd0;
  localparam logic [PolicyBits-1:0] PolBest  = 2'd1;
  localparam logic [PolicyBits-1:0] PolWorst = 2'd2;

endpackage

// ----- rtl/core/fpba_if.sv -----
// Valid/ready channel interfaces of the fit-policy block allocator.
// Depends on fpba_pkg for the fixed field widths.

// Input channel: load and allocate commands.
interface fpba_in_if #(
  parameter int unsigned SIZE_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [fpba_pkg::IndexBits-1:0]      block_index;
  logic [SIZE_BITS-1:0]                amount;
  logic [fpba_pkg::PolicyBits-1:0]     fit_policy;

  modport source (output valid, command, block_index, amount, fit_policy, input ready);
  modport sink   (input valid, command, block_index, amount, fit_policy, output ready);
endinterface

// Result channel: one transaction per allocate command with a valid fit policy.
interface fpba_out_if #(
  parameter int unsigned SIZE_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic                                fitted;
  logic [fpba_pkg::IndexBits-1:0]      chosen_block;
  logic [SIZE_BITS-1:0]                size_before;
  logic [SIZE_BITS-1:0]                size_after;

  modport source (output valid, fitted, chosen_block, size_before, size_after, input ready);
  modport sink   (input valid, fitted, chosen_block, size_before, size_after, output ready);
endinterface

// ----- rtl/core/fpba_mem.sv -----
// Free-size table of the allocator: one write port and one read port with a
// registered read. No dependencies.
module fpba_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/fpba_scan.sv -----
// Scan sequencer of the allocator: takes commands, walks the free-size table
// one entry per cycle, picks a block by policy, writes it back and holds the
// result register. Depends on fpba_pkg and the channel interfaces.
module fpba_scan #(
  parameter int unsigned MAX_BLOCKS = 64,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [$clog2(MAX_BLOCKS+1)-1:0] scan_count_i,
  fpba_in_if.sink                         in_i,
  fpba_out_if.source                      out_o,
  output logic                            mem_we_o,
  output logic [$clog2(MAX_BLOCKS)-1:0]   mem_waddr_o,
  output logic [SIZE_BITS-1:0]            mem_wdata_o,
  output logic                            mem_re_o,
  output logic [$clog2(MAX_BLOCKS)-1:0]   mem_raddr_o,
  input  logic [SIZE_BITS-1:0]            mem_rdata_i
);

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  state_e                            state_q;
  logic [CW-1:0]                     issue_q;
  logic [CW-1:0]                     cnt_q;
  logic                              rd_vld_q;
  logic [AW-1:0]                     rd_idx_q;
  logic [SIZE_BITS-1:0]              amt_q;
  logic [fpba_pkg::PolicyBits-1:0]   pol_q;
  logic                              found_q;
  logic [AW-1:0]                     pick_q;
  logic [SIZE_BITS-1:0]              pick_size_q;
  logic                              out_valid_q;
  logic                              fitted_q;
  logic [fpba_pkg::IndexBits-1:0]    chosen_q;
  logic [SIZE_BITS-1:0]              before_q;
  logic [SIZE_BITS-1:0]              after_q;

  logic in_acc;
  logic out_free;
  logic load_wr;
  logic fin_wr;
  logic hit;
  logic take;
  logic last;
  logic done;
  logic [SIZE_BITS-1:0] left_size;

  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // A load goes straight into the table; out-of-range indexes are dropped.
  assign load_wr = in_acc && (in_i.command == fpba_pkg::CmdLoad) &&
                   (32'(in_i.block_index) < MAX_BLOCKS);

  // Write-back of the chosen block once the result register can take it.
  assign left_size = pick_size_q - amt_q;
  assign fin_wr    = (state_q == StFinish) && out_free && found_q;

  always_comb begin
    mem_we_o    = load_wr || fin_wr;
    mem_waddr_o = fin_wr ? pick_q : AW'(in_i.block_index);
    mem_wdata_o = fin_wr ? left_size : in_i.amount;
  end

  // Read issue: one entry per cycle until the scan count is covered.
  assign mem_re_o    = (state_q == StScan) && (issue_q < cnt_q);
  assign mem_raddr_o = issue_q[AW-1:0];

  // Compare the returned entry against the request and the current pick.
  always_comb begin
    hit  = (mem_rdata_i >= amt_q);
    take = hit && (!found_q ||
                   ((pol_q == fpba_pkg::PolBest) && (mem_rdata_i <= pick_size_q)) ||
                   ((pol_q == fpba_pkg::PolWorst) && (mem_rdata_i > pick_size_q)));
    last = ((32'(rd_idx_q) + 32'd1) == 32'(cnt_q));
    done = rd_vld_q && (last || ((pol_q == fpba_pkg::PolFirst) && hit));
  end

  // Sequencer state and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      issue_q     <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      amt_q       <= '0;
      pol_q       <= fpba_pkg::PolFirst;
      found_q     <= 1'b0;
      pick_q      <= '0;
      pick_size_q <= '0;
      out_valid_q <= 1'b0;
      fitted_q    <= 1'b0;
      chosen_q    <= '0;
      before_q    <= '0;
      after_q     <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc && (in_i.command == fpba_pkg::CmdAlloc) &&
              ((in_i.fit_policy == fpba_pkg::PolFirst) ||
               (in_i.fit_policy == fpba_pkg::PolBest) ||
               (in_i.fit_policy == fpba_pkg::PolWorst))) begin
            amt_q    <= in_i.amount;
            pol_q    <= in_i.fit_policy;
            cnt_q    <= scan_count_i;
            issue_q  <= '0;
            rd_vld_q <= 1'b0;
            found_q  <= 1'b0;
            state_q  <= (scan_count_i == '0) ? StFinish : StScan;
          end
        end
        StScan: begin
          rd_vld_q <= mem_re_o;
          rd_idx_q <= mem_raddr_o;
          if (mem_re_o) begin
            issue_q <= issue_q + CW'(1);
          end
          if (rd_vld_q && take) begin
            found_q     <= 1'b1;
            pick_q      <= rd_idx_q;
            pick_size_q <= mem_rdata_i;
          end
          if (done) begin
            rd_vld_q <= 1'b0;
            state_q  <= StFinish;
          end
        end
        StFinish: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            fitted_q    <= found_q;
            chosen_q    <= found_q ? fpba_pkg::IndexBits'(pick_q) : '0;
            before_q    <= found_q ? pick_size_q : '0;
            after_q     <= found_q ? left_size : '0;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.fitted       = fitted_q;
  assign out_o.chosen_block = chosen_q;
  assign out_o.size_before  = before_q;
  assign out_o.size_after   = after_q;

endmodule

// ----- rtl/core/fit_policy_block_allocator.sv -----
// Top level of the fit-policy block allocator: scan-count register, free-size
// table and scan sequencer. Depends on fpba_pkg, fpba_if, fpba_mem, fpba_scan.
//
//   Channel   Direction  Handshake     Payload
//   in_i      sink       valid/ready   command, block_index, amount, fit_policy
//   out_o     source     valid/ready   fitted, chosen_block, size_before, size_after
//   cfg       write      cfg_we_i      cfg_wdata_i (blocks in use)
//
// A load transaction is written in the cycle it is accepted; the next one is
// taken in the following cycle. An allocate transaction walks the table
// through its single read port at one entry per cycle; first fit ends after
// the first fitting entry.
// Reset returns to idle with blocks in use at 64; the table is not cleared.
// A stalled result holds in the output register while the next command is
// accepted; a finished scan waits there until the register is free.
module fit_policy_block_allocator #(
  parameter int unsigned MAX_BLOCKS = 64,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fpba_pkg::CfgBits-1:0] cfg_wdata_i,
  fpba_in_if.sink                      in_i,
  fpba_out_if.source                   out_o
);

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

  logic [fpba_pkg::CfgBits-1:0] blocks_in_use_q;
  logic [CW-1:0]                scan_count;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [SIZE_BITS-1:0]         mem_wdata;
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;
  logic [SIZE_BITS-1:0]         mem_rdata;

  // Blocks-in-use register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_in_use_q <= fpba_pkg::CfgReset;
    end else if (cfg_we_i) begin
      blocks_in_use_q <= cfg_wdata_i;
    end
  end

  // The scan never goes past the table.
  always_comb begin
    if (32'(blocks_in_use_q) > MAX_BLOCKS) begin
      scan_count = CW'(MAX_BLOCKS);
    end else begin
      scan_count = CW'(blocks_in_use_q);
    end
  end

  fpba_mem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (SIZE_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fpba_scan #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scan_count_i (scan_count),
    .in_i         (in_i),
    .out_o        (out_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

endmodule

// ----- rtl/core/fpba_checker.sv -----
// Port-level checker of the fit-policy block allocator and its bind.
// Depends on fpba_pkg and the top level fit_policy_block_allocator.
module fpba_checker #(
  parameter int unsigned SIZE_BITS = 16
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            in_command_i,
  input logic [fpba_pkg::PolicyBits-1:0] in_policy_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic                            out_fitted_i,
  input logic [fpba_pkg::IndexBits-1:0]  out_chosen_i,
  input logic [SIZE_BITS-1:0]            out_before_i,
  input logic [SIZE_BITS-1:0]            out_after_i
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_fitted_i) &&
      $stable(out_chosen_i) && $stable(out_before_i) && $stable(out_after_i))
    else $error("result changed while stalled");

  // A miss reports all result fields as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_fitted_i |->
      (out_chosen_i == '0) && (out_before_i == '0) && (out_after_i == '0))
    else $error("miss with nonzero fields");

  // The size left never exceeds the size before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_fitted_i |-> out_after_i <= out_before_i)
    else $error("size after allocation grew");

  // An accepted allocate starts a scan, so the input stops taking commands.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_command_i == fpba_pkg::CmdAlloc) &&
      ((in_policy_i == fpba_pkg::PolFirst) || (in_policy_i == fpba_pkg::PolBest) ||
       (in_policy_i == fpba_pkg::PolWorst)) |=> !in_ready_i)
    else $error("command accepted during a scan");

endmodule

bind fit_policy_block_allocator fpba_checker #(
  .SIZE_BITS (SIZE_BITS)
) u_fpba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.command),
  .in_policy_i  (in_i.fit_policy),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_fitted_i (out_o.fitted),
  .out_chosen_i (out_o.chosen_block),
  .out_before_i (out_o.size_before),
  .out_after_i  (out_o.size_after)
);
